// ===== rtl/core/assert_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i with reset rst_ni.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define POL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pol: assertion failed");

// Expression must never be true outside reset.
`define POL_ASSERT_NEVER(lbl, expr) \
  `POL_ASSERT(lbl, !(expr))

`endif

// ===== rtl/core/pol_pkg.sv =====
// -----------------------------------------------------------------------------
// Ordered list package
// Sizes, codes, cell control bundle and value conversion helpers.
// -----------------------------------------------------------------------------
package pol_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned IDX_W      = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic signed [DATA_WIDTH-1:0] elem_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_SEARCH    = 3'd6
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_SRCH = 2'd3
  } cell_op_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_e op;
    idx_t     idx;
    cnt_t     cnt;
    elem_t    data;
  } cell_ctl_t;

  function automatic elem_t to_elem(input logic [VAL_W-1:0] v);
    return elem_t'(signed'(v));
  endfunction

  function automatic logic [VAL_W-1:0] from_elem(input elem_t e);
    return VAL_W'(e);
  endfunction

endpackage

// ===== rtl/core/pol_cell.sv =====
// -----------------------------------------------------------------------------
// Ordered list cell
// Holds one element, shifts toward either neighbor and compares against a key.
// -----------------------------------------------------------------------------
module pol_cell (
  input  logic              clk_i,
  input  pol_pkg::cell_ctl_t ctl_i,
  input  pol_pkg::idx_t     cell_idx_i,
  input  pol_pkg::elem_t    left_i,
  input  pol_pkg::elem_t    right_i,
  output pol_pkg::elem_t    elem_o,
  output logic              match_o
);
  import pol_pkg::*;

  elem_t elem_q, elem_d;
  logic  match_q, match_d;

  always_comb begin
    elem_d  = elem_q;
    match_d = match_q;
    case (ctl_i.op)
      CELL_INS: begin
        if (cell_idx_i == ctl_i.idx) begin
          elem_d = ctl_i.data;
        end else if (cell_idx_i > ctl_i.idx) begin
          elem_d = left_i;
        end
      end
      CELL_DEL: begin
        if (cell_idx_i >= ctl_i.idx) begin
          elem_d = right_i;
        end
      end
      CELL_SRCH: begin
        // Cells at or beyond the count hold stale data and must not match.
        match_d = (elem_q == ctl_i.data) && (CNT_W'(cell_idx_i) < ctl_i.cnt);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    elem_q  <= elem_d;
    match_q <= match_d;
  end

  assign elem_o  = elem_q;
  assign match_o = match_q;

endmodule

// ===== rtl/core/pol_ffs.sv =====
// -----------------------------------------------------------------------------
// Ordered list first-match encoder
// Finds the lowest set match flag and returns its 1-based position.
// -----------------------------------------------------------------------------
module pol_ffs (
  input  logic [pol_pkg::CAPACITY-1:0] match_i,
  output logic                         found_o,
  output pol_pkg::cnt_t                pos_o
);
  import pol_pkg::*;

  logic [CAPACITY-1:0] lowest;
  idx_t                idx;

  // Isolate the lowest set bit, then encode the one-hot word by OR.
  assign lowest = match_i & (~match_i + CAPACITY'(1));

  always_comb begin
    idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (lowest[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
  end

  assign found_o = |match_i;
  assign pos_o   = CNT_W'(idx) + CNT_W'(1);

endmodule

// ===== rtl/core/positional_ordered_list_unit.sv =====
// An input transfer is taken into the cells and the s1 registers, and no other is
// taken while s1 holds it; the first-match encoder over the registered match flags
// then feeds the output register, which loads when it is empty or not stalled.
// A result held by an output stall also holds off the next input transfer.
// Reset clears the element count and both valid flags; element storage is not
// cleared, and entries at or beyond the count are never observed.
// -----------------------------------------------------------------------------
// Positional ordered list unit
// Bounded ordered list kept in a chain of shifting cells, with insert, delete
// and search by position or key.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_ordered_list_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                opcode_i,
  input  logic [pol_pkg::VAL_W-1:0] value_i,
  input  logic [pol_pkg::POS_W-1:0] position_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [pol_pkg::VAL_W-1:0] result_value_o,
  output logic [pol_pkg::POS_W-1:0] found_position_o,
  output logic [pol_pkg::POS_W-1:0] element_count_o
);
  import pol_pkg::*;

  elem_t               elems [CAPACITY];
  logic [CAPACITY-1:0] match;
  cell_ctl_t           ctl;

  logic                in_fire;
  logic                out_load;
  logic                full;
  logic [CMP_W-1:0]    pos_w, cnt_w;

  cnt_t                count_q, count_d;
  status_e             st;
  logic [VAL_W-1:0]    rval;
  logic                srch;

  logic                s1_vld_q, s1_vld_d;
  status_e             s1_status_q;
  logic [VAL_W-1:0]    s1_rval_q;
  cnt_t                s1_cnt_q;
  logic                s1_srch_q;

  logic                out_vld_q, out_vld_d;
  status_e             out_status_q, out_status_d;
  logic [VAL_W-1:0]    out_rval_q;
  cnt_t                out_cnt_q;
  cnt_t                out_fpos_q, out_fpos_d;

  logic                hit;
  cnt_t                hit_pos;

  // One operation is in flight at a time; the result register may still be
  // holding an earlier result while the next transfer is taken.
  assign in_stall_o = s1_vld_q || (out_vld_q && out_stall_i);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_load   = s1_vld_q && (!out_vld_q || !out_stall_i);

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign pos_w = CMP_W'(position_i);
  assign cnt_w = CMP_W'(count_q);

  always_comb begin
    st       = ST_OK;
    rval     = '0;
    srch     = 1'b0;
    count_d  = count_q;
    ctl.op   = CELL_HOLD;
    ctl.idx  = '0;
    ctl.cnt  = count_q;
    ctl.data = to_elem(value_i);
    case (opcode_e'(opcode_i))
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          ctl.op  = CELL_INS;
          count_d = count_q + CNT_W'(1);
          if (opcode_e'(opcode_i) == OP_INS_FRONT) begin
            ctl.idx = '0;
          end else if (opcode_e'(opcode_i) == OP_INS_BACK) begin
            ctl.idx = IDX_W'(count_q);
          end else if (pos_w <= CMP_W'(1)) begin
            ctl.idx = '0;
          end else if (pos_w > cnt_w) begin
            // Past the end appends.
            ctl.idx = IDX_W'(count_q);
          end else begin
            ctl.idx = IDX_W'(pos_w - CMP_W'(1));
          end
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
        if (count_q == '0) begin
          st = ST_EMPTY;
        end else if (opcode_e'(opcode_i) == OP_DEL_AT && pos_w > cnt_w) begin
          st = ST_NOT_FOUND;
        end else begin
          ctl.op  = CELL_DEL;
          count_d = count_q - CNT_W'(1);
          if (opcode_e'(opcode_i) == OP_DEL_FRONT) begin
            ctl.idx = '0;
          end else if (opcode_e'(opcode_i) == OP_DEL_BACK) begin
            ctl.idx = IDX_W'(count_q - CNT_W'(1));
          end else if (pos_w <= CMP_W'(1)) begin
            ctl.idx = '0;
          end else begin
            ctl.idx = IDX_W'(pos_w - CMP_W'(1));
          end
        end
      end
      OP_SEARCH: begin
        ctl.op = CELL_SRCH;
        srch   = 1'b1;
        rval   = from_elem(to_elem(value_i));
      end
      default: begin
      end
    endcase
    if (ctl.op == CELL_DEL) begin
      rval = from_elem(elems[ctl.idx]);
    end
    if (!in_fire) begin
      ctl.op  = CELL_HOLD;
      count_d = count_q;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    elem_t left, right;
    if (g == 0) begin : g_head
      assign left = ctl.data;
    end else begin : g_mid_l
      assign left = elems[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right = elems[g];
    end else begin : g_mid_r
      assign right = elems[g+1];
    end
    pol_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .cell_idx_i (IDX_W'(g)),
      .left_i     (left),
      .right_i    (right),
      .elem_o     (elems[g]),
      .match_o    (match[g])
    );
  end

  pol_ffs u_ffs (
    .match_i (match),
    .found_o (hit),
    .pos_o   (hit_pos)
  );

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_fire) begin
      s1_vld_d = 1'b1;
    end else if (out_load) begin
      s1_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d    = out_load || (out_vld_q && out_stall_i);
    out_status_d = s1_status_q;
    out_fpos_d   = '0;
    if (s1_srch_q) begin
      if (hit) begin
        out_status_d = ST_OK;
        out_fpos_d   = hit_pos;
      end else begin
        out_status_d = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_status_q <= st;
      s1_rval_q   <= rval;
      s1_cnt_q    <= count_d;
      s1_srch_q   <= srch;
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_rval_q   <= s1_rval_q;
      out_cnt_q    <= s1_cnt_q;
      out_fpos_q   <= out_fpos_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign status_o         = out_status_q;
  assign result_value_o   = out_rval_q;
  assign found_position_o = POS_W'(out_fpos_q);
  assign element_count_o  = POS_W'(out_cnt_q);

  `POL_ASSERT(a_count_range, count_q <= CNT_W'(CAPACITY))
  `POL_ASSERT(a_accept_fills_s1, in_fire |=> s1_vld_q)
  `POL_ASSERT(a_full_status, (out_vld_q && out_status_q == ST_FULL) |-> (out_cnt_q == CNT_W'(CAPACITY)))
  `POL_ASSERT_NEVER(a_no_overlap, s1_vld_q && in_fire)

endmodule
